/* rtl/core/csfw_pkg.sv */
package csfw_pkg;

  localparam int NUM_SEMAPHORES_DEF = 8;
  localparam int MAX_WAITERS_DEF    = 64;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 3;
  localparam int PID_W   = 7;
  localparam int CEIL_W  = 7;
  localparam int CNT_W   = 8;

  localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic signed [CNT_W-1:0] CNT_MIN = 8'sh80;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch request fields, read semaphore record
    logic calc;      // update record, access waiter store
    logic load_out;  // move result into output register
  } ctrl_cmd_t;

endpackage

/* rtl/core/csfw_if.sv */
interface csfw_req_if;
  logic                             valid;
  logic                             ready;
  logic [csfw_pkg::CMD_W-1:0]       command;
  logic [csfw_pkg::INDEX_W-1:0]     sem_index;
  logic [csfw_pkg::PID_W-1:0]       process_id;
  logic [csfw_pkg::CEIL_W-1:0]      init_value;
  logic [csfw_pkg::CEIL_W-1:0]      init_offset;

  modport source(output valid, command, sem_index, process_id, init_value, init_offset,
                 input ready);
  modport sink(input valid, command, sem_index, process_id, init_value, init_offset,
               output ready);
endinterface

interface csfw_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             blocked;
  logic                             wake_valid;
  logic [csfw_pkg::PID_W-1:0]       woken_process;
  logic signed [csfw_pkg::CNT_W-1:0] count_after;
  logic                             queue_full_error;

  modport source(output valid, blocked, wake_valid, woken_process, count_after,
                 queue_full_error, input ready);
  modport sink(input valid, blocked, wake_valid, woken_process, count_after,
               queue_full_error, output ready);
endinterface

/* rtl/core/counting_semaphore_fifo_waiters_top.sv */
// a request passes through the registered record read, the record update with its waiter
// store access, and the load of the output register, which waits until that register is free
// a new request is taken only after the previous one has been loaded into the output register;
// a new request is taken while the previous response waits in the output register
// reset (rst, synchronous) empties every queue and clears every count and ceiling
// through per-semaphore valid bits; no clearing pass, ready in the first cycle after
module counting_semaphore_fifo_waiters_top #(
  parameter int NUM_SEMAPHORES = csfw_pkg::NUM_SEMAPHORES_DEF,
  parameter int MAX_WAITERS    = csfw_pkg::MAX_WAITERS_DEF
) (
  input logic        clk,
  input logic        rst,
  csfw_req_if.sink   req,
  csfw_rsp_if.source rsp
);

  csfw_pkg::ctrl_cmd_t cmd;

  csfw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  csfw_datapath #(
    .NUM_SEMAPHORES (NUM_SEMAPHORES),
    .MAX_WAITERS    (MAX_WAITERS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .command          (req.command),
    .sem_index        (req.sem_index),
    .process_id       (req.process_id),
    .init_value       (req.init_value),
    .init_offset      (req.init_offset),
    .blocked          (rsp.blocked),
    .wake_valid       (rsp.wake_valid),
    .woken_process    (rsp.woken_process),
    .count_after      (rsp.count_after),
    .queue_full_error (rsp.queue_full_error)
  );

endmodule

/* rtl/core/csfw_ctrl.sv */
module csfw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output csfw_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.calc     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // wait until the output register is empty or draining
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/csfw_datapath.sv */
module csfw_datapath #(
  parameter int NUM_SEMAPHORES = csfw_pkg::NUM_SEMAPHORES_DEF,
  parameter int MAX_WAITERS    = csfw_pkg::MAX_WAITERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  csfw_pkg::ctrl_cmd_t                cmd,
  input  logic [csfw_pkg::CMD_W-1:0]         command,
  input  logic [csfw_pkg::INDEX_W-1:0]       sem_index,
  input  logic [csfw_pkg::PID_W-1:0]         process_id,
  input  logic [csfw_pkg::CEIL_W-1:0]        init_value,
  input  logic [csfw_pkg::CEIL_W-1:0]        init_offset,
  output logic                               blocked,
  output logic                               wake_valid,
  output logic [csfw_pkg::PID_W-1:0]         woken_process,
  output logic signed [csfw_pkg::CNT_W-1:0]  count_after,
  output logic                               queue_full_error
);

  localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int QW = $clog2(MAX_WAITERS);
  localparam int LW = $clog2(MAX_WAITERS + 1);
  localparam int AW = $clog2(NUM_SEMAPHORES * MAX_WAITERS);
  localparam int STORE_DEPTH = NUM_SEMAPHORES * MAX_WAITERS;

  typedef struct packed {
    logic signed [csfw_pkg::CNT_W-1:0] count;
    logic [csfw_pkg::CEIL_W-1:0]       ceiling;
    logic [QW-1:0]                     head;
    logic [LW-1:0]                     length;
  } rec_t;

  // semaphore records, with per-entry valid bits standing in for the reset
  rec_t rec_mem [NUM_SEMAPHORES];
  logic [NUM_SEMAPHORES-1:0] rec_vld;
  logic [csfw_pkg::PID_W-1:0] waiter_mem [STORE_DEPTH];

  logic [csfw_pkg::CMD_W-1:0]  command_q;
  logic [SW-1:0]               idx_q;
  logic                        in_range_q;
  logic [csfw_pkg::PID_W-1:0]  pid_q;
  logic [csfw_pkg::CEIL_W-1:0] value_q;
  logic [csfw_pkg::CEIL_W-1:0] offset_q;
  rec_t                        rec_rd;
  logic                        vld_rd;

  logic                              blocked_r;
  logic                              wake_r;
  logic                              full_r;
  logic signed [csfw_pkg::CNT_W-1:0] count_r;
  logic [csfw_pkg::PID_W-1:0]        waiter_rd;

  logic [SW-1:0] idx_in;
  logic          in_range_in;

  assign idx_in      = SW'(sem_index);
  assign in_range_in = 32'(sem_index) < 32'(NUM_SEMAPHORES);

  // update of the selected record
  rec_t                              cur;
  rec_t                              upd;
  logic signed [csfw_pkg::CNT_W-1:0] cnt_dec;
  logic signed [csfw_pkg::CNT_W-1:0] cnt_inc;
  logic [LW:0]                       tail_sum;
  logic [QW-1:0]                     tail_pos;
  logic [QW-1:0]                     head_inc;
  logic                              push;
  logic                              pop;
  logic                              full_c;
  logic [AW-1:0]                     waddr;

  always_comb begin
    cur      = vld_rd ? rec_rd : '0;
    upd      = cur;
    push     = 1'b0;
    pop      = 1'b0;
    full_c   = 1'b0;
    cnt_dec  = (cur.count != csfw_pkg::CNT_MIN) ? cur.count - 8'sd1 : cur.count;
    cnt_inc  = (cur.count < $signed({1'b0, cur.ceiling})) ? cur.count + 8'sd1 : cur.count;
    tail_sum = (LW+1)'(cur.head) + (LW+1)'(cur.length);
    if (tail_sum >= (LW+1)'(MAX_WAITERS)) begin
      tail_sum = tail_sum - (LW+1)'(MAX_WAITERS);
    end
    tail_pos = QW'(tail_sum);
    head_inc = (cur.head == QW'(MAX_WAITERS - 1)) ? '0 : cur.head + 1'b1;
    case (command_q)
      csfw_pkg::CMD_INIT: begin
        upd.count   = csfw_pkg::CNT_W'({1'b0, value_q}) - csfw_pkg::CNT_W'({1'b0, offset_q});
        upd.ceiling = value_q;
        upd.head    = '0;
        upd.length  = '0;
      end
      csfw_pkg::CMD_ACQUIRE: begin
        upd.count = cnt_dec;
        if (cnt_dec[csfw_pkg::CNT_W-1]) begin
          if (cur.length < LW'(MAX_WAITERS)) begin
            push       = 1'b1;
            upd.length = cur.length + 1'b1;
          end else begin
            full_c = 1'b1;
          end
        end
      end
      csfw_pkg::CMD_RELEASE: begin
        upd.count = cnt_inc;
        if ((cnt_inc[csfw_pkg::CNT_W-1] || cnt_inc == '0) && cur.length != '0) begin
          pop        = 1'b1;
          upd.head   = head_inc;
          upd.length = cur.length - 1'b1;
        end
      end
      default: begin
        upd = cur;
      end
    endcase
    waddr = AW'(AW'(idx_q) * AW'(MAX_WAITERS)) + AW'(push ? tail_pos : cur.head);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_vld <= '0;
    end else if (cmd.calc && in_range_q) begin
      rec_vld[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_q  <= command;
      idx_q      <= idx_in;
      in_range_q <= in_range_in;
      pid_q      <= process_id;
      value_q    <= init_value;
      offset_q   <= init_offset;
      rec_rd     <= rec_mem[idx_in];
      vld_rd     <= rec_vld[idx_in];
    end
    if (cmd.calc) begin
      if (in_range_q) begin
        rec_mem[idx_q] <= upd;
      end
      blocked_r <= in_range_q && push;
      wake_r    <= in_range_q && pop;
      full_r    <= in_range_q && full_c;
      count_r   <= in_range_q ? upd.count : '0;
    end
  end

  // waiter store: one port, written on push, read on pop
  always_ff @(posedge clk) begin
    if (cmd.calc && in_range_q) begin
      if (push) begin
        waiter_mem[waddr] <= pid_q;
      end else if (pop) begin
        waiter_rd <= waiter_mem[waddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      blocked          <= blocked_r;
      wake_valid       <= wake_r;
      woken_process    <= wake_r ? waiter_rd : '0;
      count_after      <= count_r;
      queue_full_error <= full_r;
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import csfw_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_SEMS = NUM_SEMAPHORES_DEF;
  localparam int QUEUE_DEPTH = MAX_WAITERS_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int TARGET_COMMANDS = 1850;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] sem_index;
    logic [PID_W-1:0]   process_id;
    logic [CEIL_W-1:0]  init_value;
    logic [CEIL_W-1:0]  init_offset;
  } sem_cmd_t;

  typedef struct packed {
    logic                    blocked;
    logic                    wake_valid;
    logic [PID_W-1:0]        woken_process;
    logic signed [CNT_W-1:0] count_after;
    logic                    queue_full_error;
  } sem_result_t;

  class sem_bank_scoreboard;
    int                count_val[NUM_SEMS];
    logic [CEIL_W-1:0] ceiling[NUM_SEMS];
    int                head[NUM_SEMS];
    int                length[NUM_SEMS];
    logic [PID_W-1:0]  waiters[NUM_SEMS][QUEUE_DEPTH];
    sem_result_t       pending_outcomes[$];
    int errors;
    int checked;
    int n_blocked;
    int n_woken;
    int n_full;

    function new();
      for (int i = 0; i < NUM_SEMS; i++) begin
        count_val[i] = 0;
        ceiling[i] = '0;
        head[i] = 0;
        length[i] = 0;
      end
      errors = 0;
      checked = 0;
      n_blocked = 0;
      n_woken = 0;
      n_full = 0;
    endfunction

    function sem_result_t apply_command(sem_cmd_t c);
      sem_result_t o;
      int s;
      int pos;
      o = '0;
      s = int'(c.sem_index);
      case (c.command)
        CMD_INIT: begin
          count_val[s] = int'(c.init_value) - int'(c.init_offset);
          ceiling[s] = c.init_value;
          head[s] = 0;
          length[s] = 0;
        end
        CMD_ACQUIRE: begin
          if (count_val[s] > -128) count_val[s]--;
          if (count_val[s] < 0) begin
            if (length[s] < QUEUE_DEPTH) begin
              pos = (head[s] + length[s]) % QUEUE_DEPTH;
              waiters[s][pos] = c.process_id;
              length[s]++;
              o.blocked = 1'b1;
            end else begin
              o.queue_full_error = 1'b1;
            end
          end
        end
        CMD_RELEASE: begin
          if (count_val[s] < int'(ceiling[s])) count_val[s]++;
          if (count_val[s] <= 0 && length[s] > 0) begin
            o.woken_process = waiters[s][head[s]];
            o.wake_valid = 1'b1;
            head[s] = (head[s] + 1) % QUEUE_DEPTH;
            length[s]--;
          end
        end
        default: ;
      endcase
      o.count_after = count_val[s][CNT_W-1:0];
      return o;
    endfunction

    function void note_request(sem_cmd_t c);
      sem_result_t e;
      e = apply_command(c);
      n_blocked += int'(e.blocked);
      n_woken += int'(e.wake_valid);
      n_full += int'(e.queue_full_error);
      pending_outcomes.push_back(e);
    endfunction

    task report(string what);
      $display("mismatch at response %0d: %s", checked, what);
      errors++;
    endtask

    task check_response(sem_result_t got);
      sem_result_t want;
      if (pending_outcomes.size() == 0) begin
        report("response with no command outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        if (got.blocked !== want.blocked)
          report($sformatf("blocked got %b want %b", got.blocked, want.blocked));
        if (got.wake_valid !== want.wake_valid)
          report($sformatf("wake_valid got %b want %b", got.wake_valid, want.wake_valid));
        if (got.woken_process !== want.woken_process)
          report($sformatf("woken_process got %0d want %0d",
                           got.woken_process, want.woken_process));
        if (got.count_after !== want.count_after)
          report($sformatf("count_after got %0d want %0d",
                           got.count_after, want.count_after));
        if (got.queue_full_error !== want.queue_full_error)
          report($sformatf("queue_full_error got %b want %b",
                           got.queue_full_error, want.queue_full_error));
      end
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;

  csfw_req_if req_ch();
  csfw_rsp_if rsp_ch();

  counting_semaphore_fifo_waiters_top uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  sem_bank_scoreboard sb;
  int  sent;
  int  idle_cycles;
  bit  fast_source;
  bit  slow_sink;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic sem_cmd_t mk(logic [CMD_W-1:0] cmd, int sem, int pid);
    sem_cmd_t c;
    c.command = cmd;
    c.sem_index = INDEX_W'(sem);
    c.process_id = PID_W'(pid);
    c.init_value = CEIL_W'($urandom_range(0, 127));
    c.init_offset = CEIL_W'($urandom_range(0, 127));
    return c;
  endfunction

  function automatic sem_cmd_t mk_init(int sem, int v, int m);
    sem_cmd_t c;
    c = mk(CMD_INIT, sem, $urandom_range(0, 127));
    c.init_value = CEIL_W'(v);
    c.init_offset = CEIL_W'(m);
    return c;
  endfunction

  function automatic int rand_pid();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
    return $urandom_range(1, 64);
  endfunction

  // entered and left at a falling edge
  task send(sem_cmd_t c);
    int gap;
    gap = fast_source ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= c.command;
    req_ch.sem_index <= c.sem_index;
    req_ch.process_id <= c.process_id;
    req_ch.init_value <= c.init_value;
    req_ch.init_offset <= c.init_offset;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(c);
    sent++;
    @(negedge clk);
  endtask

  // response side: per-transaction stall, with stretches of none
  initial begin : response_side
    int stall;
    rsp_ch.ready = 1'b0;
    slow_sink = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) slow_sink = !slow_sink;
      stall = slow_sink ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response({rsp_ch.blocked, rsp_ch.wake_valid, rsp_ch.woken_process,
                         rsp_ch.count_after, rsp_ch.queue_full_error});
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int sem;
    int n;
    int k;
    int v;
    int m;
    bit first;
    sb = new();
    sent = 0;
    idle_cycles = 0;
    fast_source = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_INIT;
    req_ch.sem_index = '0;
    req_ch.process_id = '0;
    req_ch.init_value = '0;
    req_ch.init_offset = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // release at a zero ceiling, then a single wait and wake
    send(mk(CMD_RELEASE, 0, 1));
    send(mk(CMD_ACQUIRE, 0, 1));
    send(mk(CMD_RELEASE, 0, 9));
    // top of range and release at ceiling
    send(mk_init(1, 127, 0));
    send(mk(CMD_ACQUIRE, 1, 64));
    send(mk(CMD_RELEASE, 1, 3));
    send(mk(CMD_RELEASE, 1, 3));
    // bottom of range, saturation, odd ids 0 and 127
    send(mk_init(2, 0, 127));
    send(mk(CMD_ACQUIRE, 2, 0));
    send(mk(CMD_ACQUIRE, 2, 127));
    send(mk(CMD_RELEASE, 2, 4));
    send(mk(CMD_RELEASE, 2, 4));
    send(mk(CMD_RELEASE, 2, 4));
    send(mk(CMD_UNUSED, 2, 127));
    // init empties a nonempty queue
    send(mk_init(7, 127, 127));
    send(mk(CMD_ACQUIRE, 7, 5));
    send(mk_init(7, 5, 0));
    send(mk(CMD_RELEASE, 7, 5));
    send(mk(CMD_UNUSED, 5, 0));
    send(mk_init(3, 1, 0));
    send(mk(CMD_ACQUIRE, 3, 2));
    send(mk(CMD_ACQUIRE, 3, 3));
    send(mk(CMD_RELEASE, 3, 6));

    first = 1'b1;
    while (sent < TARGET_COMMANDS) begin
      fast_source = ($urandom_range(0, 4) == 0);
      sem = $urandom_range(0, NUM_SEMS - 1);
      if (first || $urandom_range(0, 9) == 0) begin
        // fill one queue to near or past its depth, then drain part or all of it
        send(mk_init(sem, $urandom_range(0, 3), 0));
        n = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 6);
        repeat (n) send(mk(CMD_ACQUIRE, sem, rand_pid()));
        n = $urandom_range(20, QUEUE_DEPTH + 8);
        repeat (n) send(mk(CMD_RELEASE, sem, rand_pid()));
      end else if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(3, 10);
        repeat (n) send(mk(CMD_W'($urandom_range(0, 3)), $urandom_range(0, NUM_SEMS - 1),
                           $urandom_range(0, 127)));
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
          m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, v + 3);
          send(mk_init(sem, v, m));
        end
        n = $urandom_range(10, 40);
        repeat (n) begin
          k = $urandom_range(0, 19);
          if (k < 10) send(mk(CMD_ACQUIRE, sem, rand_pid()));
          else if (k < 19) send(mk(CMD_RELEASE, sem, rand_pid()));
          else send(mk(CMD_UNUSED, sem, rand_pid()));
        end
      end
      first = 1'b0;
    end

    req_ch.valid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.pending_outcomes.size() != 0) sb.report("responses missing at end of run");

    $display("run: %0d commands sent, %0d responses checked", sent, sb.checked);
    $display("run: %0d blocked, %0d woken, %0d queue-full rejections",
             sb.n_blocked, sb.n_woken, sb.n_full);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
